// ===== rtl/core/vpzm_pkg.sv =====
// Shared types and constants for the viewport pan and zoom mapper.
package vpzm_pkg;

	localparam int KIND_W  = 3;
	localparam int PIX_W   = 16;
	localparam int SIZE_W  = 11;
	localparam int COORD_W = 32;
	localparam int REST_W  = 12;
	// dividend of the shared divider: remainder minus drag, or an anchor pixel
	localparam int DIV_W   = 18;
	localparam int DVSR_W  = 12;
	localparam int CNT_W   = $clog2(DIV_W);

	localparam int IN_DATA_W  = 144;
	localparam int OUT_DATA_W = 208;

	localparam logic [DVSR_W-1:0] CELL_SIZE_CAP = DVSR_W'(1024);

	localparam logic [KIND_W-1:0] KIND_PAN       = 3'd0;
	localparam logic [KIND_W-1:0] KIND_END_PAN   = 3'd1;
	localparam logic [KIND_W-1:0] KIND_ZOOM_IN   = 3'd2;
	localparam logic [KIND_W-1:0] KIND_ZOOM_OUT  = 3'd3;
	localparam logic [KIND_W-1:0] KIND_ZOOM_SIZE = 3'd4;
	localparam logic [KIND_W-1:0] KIND_TO_BOARD  = 3'd5;
	localparam logic [KIND_W-1:0] KIND_TO_SCREEN = 3'd6;

	localparam logic REG_LARGEST  = 1'b0;
	localparam logic REG_SMALLEST = 1'b1;

	typedef logic [SIZE_W-1:0]         size_t;
	typedef logic [COORD_W-1:0]        coord_t;
	typedef logic signed [DIV_W-1:0]   quo_t;
	typedef logic signed [REST_W-1:0]  rest_t;

endpackage

// ===== rtl/core/viewport_pan_zoom_mapper.sv =====
// Viewport pan and zoom mapper: origin, cell size and pan remainders with screen/board mapping.
//
// One transaction in, one result out. All divisions go through a single
// restoring divider that retires one quotient bit per cycle, with a load and a
// store state around each division. Pan and screen-to-board use two divisions,
// an accepted zoom uses four, and board-to-screen uses the shared multiplier
// twice; end pan, a refused zoom and an unused kind go from decode straight to
// finish. s_tready rises at the same edge as m_tvalid. s_tready is high only
// while no transaction is in work; a finished result waits in the output
// register and the next transaction can be taken meanwhile, but its own result
// holds until that register is free.
module viewport_pan_zoom_mapper #(
	parameter int START_CELL_SIZE = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic                                 cfg_index,
	input  logic [vpzm_pkg::SIZE_W-1:0]          cfg_data,
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	// drag_dx[15:0], drag_dy[31:16], pixel_x[47:32], pixel_y[63:48],
	// target_cell_size[74:64], cell_x[106:75], cell_y[138:107], zero fill
	input  logic [vpzm_pkg::IN_DATA_W-1:0]       s_tdata,
	// kind[2:0]
	input  logic [vpzm_pkg::KIND_W-1:0]          s_tuser,
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	// zoom_done[0], mapped_board_x[32:1], mapped_board_y[64:33],
	// mapped_screen_x[96:65], mapped_screen_y[128:97], origin_x[160:129],
	// origin_y[192:161], current_cell_size[203:193], zero fill
	output logic [vpzm_pkg::OUT_DATA_W-1:0]      m_tdata
);

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_DECODE = 3'd1;
	localparam logic [2:0] ST_MUL    = 3'd2;
	localparam logic [2:0] ST_LOAD   = 3'd3;
	localparam logic [2:0] ST_ITER   = 3'd4;
	localparam logic [2:0] ST_STORE  = 3'd5;
	localparam logic [2:0] ST_FINISH = 3'd6;

	localparam int DW = vpzm_pkg::DIV_W;
	localparam int VW = vpzm_pkg::DVSR_W;
	localparam int CW = vpzm_pkg::COORD_W;

	logic [2:0] state_q;

	// configuration
	vpzm_pkg::size_t largest_q, smallest_q;

	// viewport state
	vpzm_pkg::coord_t origin_x_q, origin_y_q;
	vpzm_pkg::size_t  cell_q;
	vpzm_pkg::rest_t  rest_x_q, rest_y_q;

	// captured transaction
	logic [vpzm_pkg::KIND_W-1:0]     kind_q;
	logic signed [vpzm_pkg::PIX_W-1:0] dx_q, dy_q, px_q, py_q;
	vpzm_pkg::size_t                 target_q;
	vpzm_pkg::coord_t                bx_q, by_q;

	// sequencer
	logic [1:0]      step_q;
	logic            zoom_ok_q;
	logic [VW-1:0]   new_size_q;
	vpzm_pkg::quo_t  quo_q [4];
	vpzm_pkg::rest_t rem_q [2];
	vpzm_pkg::coord_t mul_q [2];

	// divider
	logic [DW-1:0]                 dmag_q;
	logic [VW-1:0]                 drem_q;
	logic [VW-1:0]                 dvsr_q;
	logic                          dneg_q;
	logic [vpzm_pkg::CNT_W-1:0]    cnt_q;

	// output register
	logic                                  out_valid_q;
	logic [vpzm_pkg::OUT_DATA_W-1:0]       out_data_q;

	logic                  is_zoom;
	logic                  last_step;
	logic [VW-1:0]         cell_ext;
	logic [VW-1:0]         cell_dvsr;
	logic [VW-1:0]         zoom_cand;
	logic                  zoom_ok;
	logic signed [DW-1:0]  dividend;
	logic [VW-1:0]         divisor_sel;
	logic [VW-1:0]         trial;
	logic                  trial_ge;
	vpzm_pkg::quo_t        q_signed;
	vpzm_pkg::rest_t       r_signed;
	vpzm_pkg::coord_t      mul_diff;
	vpzm_pkg::coord_t      mul_prod;
	logic                  out_free;

	vpzm_pkg::coord_t nox, noy, nmbx, nmby, nmsx, nmsy;
	vpzm_pkg::size_t  ncell;
	vpzm_pkg::rest_t  nrx, nry;
	logic             ndone;

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign out_free = !out_valid_q || m_tready;

	assign is_zoom   = kind_q inside {vpzm_pkg::KIND_ZOOM_IN, vpzm_pkg::KIND_ZOOM_OUT,
		vpzm_pkg::KIND_ZOOM_SIZE};
	assign last_step = is_zoom ? (step_q == 2'd3) : (step_q == 2'd1);
	assign cell_ext  = VW'(cell_q);
	assign cell_dvsr = (cell_q == '0) ? VW'(1) : cell_ext;

	// candidate size; zero stands for a zoom already refused by the limits
	always_comb begin
		zoom_cand = '0;
		case (kind_q)
			vpzm_pkg::KIND_ZOOM_IN: begin
				if (cell_q < largest_q)
					zoom_cand = cell_ext << 1;
			end
			vpzm_pkg::KIND_ZOOM_OUT: begin
				if (cell_q > smallest_q)
					zoom_cand = cell_ext >> 1;
			end
			vpzm_pkg::KIND_ZOOM_SIZE: begin
				zoom_cand = VW'(target_q);
			end
			default: begin
				zoom_cand = '0;
			end
		endcase
	end

	assign zoom_ok = (zoom_cand != '0) && (zoom_cand <= vpzm_pkg::CELL_SIZE_CAP)
		&& (zoom_cand != cell_ext);

	// operand selection for the shared divider
	always_comb begin
		if (kind_q == vpzm_pkg::KIND_PAN) begin
			if (step_q[0])
				dividend = DW'(rest_y_q) - DW'(dy_q);
			else
				dividend = DW'(rest_x_q) - DW'(dx_q);
		end else begin
			if (step_q[0])
				dividend = DW'(py_q);
			else
				dividend = DW'(px_q);
		end
		divisor_sel = step_q[1] ? new_size_q : cell_dvsr;
	end

	assign trial    = {drem_q[VW-2:0], dmag_q[DW-1]};
	assign trial_ge = (trial >= dvsr_q);
	assign q_signed = dneg_q ? -$signed(dmag_q) : $signed(dmag_q);
	assign r_signed = dneg_q ? -$signed(drem_q) : $signed(drem_q);

	assign mul_diff = step_q[0] ? (by_q - origin_y_q) : (bx_q - origin_x_q);
	assign mul_prod = CW'(mul_diff * CW'(cell_q));

	// state update and result of the finished transaction
	always_comb begin
		nox   = origin_x_q;
		noy   = origin_y_q;
		ncell = cell_q;
		nrx   = rest_x_q;
		nry   = rest_y_q;
		ndone = 1'b0;
		nmbx  = '0;
		nmby  = '0;
		nmsx  = '0;
		nmsy  = '0;
		case (kind_q)
			vpzm_pkg::KIND_PAN: begin
				nox = origin_x_q + CW'(quo_q[0]);
				noy = origin_y_q + CW'(quo_q[1]);
				nrx = rem_q[0];
				nry = rem_q[1];
			end
			vpzm_pkg::KIND_END_PAN: begin
				nrx = '0;
				nry = '0;
			end
			vpzm_pkg::KIND_ZOOM_IN, vpzm_pkg::KIND_ZOOM_OUT, vpzm_pkg::KIND_ZOOM_SIZE: begin
				if (zoom_ok_q) begin
					nox   = origin_x_q + CW'(quo_q[0]) - CW'(quo_q[2]);
					noy   = origin_y_q + CW'(quo_q[1]) - CW'(quo_q[3]);
					ncell = vpzm_pkg::SIZE_W'(new_size_q);
					nrx   = '0;
					nry   = '0;
					ndone = 1'b1;
				end
			end
			vpzm_pkg::KIND_TO_BOARD: begin
				nmbx = origin_x_q + CW'(quo_q[0]);
				nmby = origin_y_q + CW'(quo_q[1]);
			end
			vpzm_pkg::KIND_TO_SCREEN: begin
				nmsx = mul_q[0];
				nmsy = mul_q[1];
			end
			default: begin
				ndone = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			largest_q   <= vpzm_pkg::SIZE_W'(64);
			smallest_q  <= vpzm_pkg::SIZE_W'(1);
			origin_x_q  <= '0;
			origin_y_q  <= '0;
			cell_q      <= vpzm_pkg::SIZE_W'(START_CELL_SIZE);
			rest_x_q    <= '0;
			rest_y_q    <= '0;
			step_q      <= '0;
			zoom_ok_q   <= 1'b0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == vpzm_pkg::REG_LARGEST)
					largest_q <= cfg_data;
				else
					smallest_q <= cfg_data;
			end

			// load a finished result, else drop the one just taken
			if (state_q == ST_FINISH && out_free)
				out_valid_q <= 1'b1;
			else if (m_tready)
				out_valid_q <= 1'b0;

			case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						step_q  <= '0;
						state_q <= ST_DECODE;
					end
				end
				ST_DECODE: begin
					zoom_ok_q <= zoom_ok;
					case (kind_q)
						vpzm_pkg::KIND_PAN, vpzm_pkg::KIND_TO_BOARD: begin
							state_q <= ST_LOAD;
						end
						vpzm_pkg::KIND_ZOOM_IN, vpzm_pkg::KIND_ZOOM_OUT,
						vpzm_pkg::KIND_ZOOM_SIZE: begin
							state_q <= zoom_ok ? ST_LOAD : ST_FINISH;
						end
						vpzm_pkg::KIND_TO_SCREEN: begin
							state_q <= ST_MUL;
						end
						default: begin
							state_q <= ST_FINISH;
						end
					endcase
				end
				ST_MUL: begin
					step_q <= step_q + 2'd1;
					if (step_q[0])
						state_q <= ST_FINISH;
				end
				ST_LOAD: begin
					cnt_q   <= '0;
					state_q <= ST_ITER;
				end
				ST_ITER: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == vpzm_pkg::CNT_W'(DW - 1))
						state_q <= ST_STORE;
				end
				ST_STORE: begin
					if (last_step) begin
						state_q <= ST_FINISH;
					end else begin
						step_q  <= step_q + 2'd1;
						state_q <= ST_LOAD;
					end
				end
				ST_FINISH: begin
					// hold until the output register is free
					if (out_free) begin
						origin_x_q  <= nox;
						origin_y_q  <= noy;
						cell_q      <= ncell;
						rest_x_q    <= nrx;
						rest_y_q    <= nry;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// payload and datapath registers
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && s_tvalid) begin
			kind_q   <= s_tuser;
			dx_q     <= s_tdata[15:0];
			dy_q     <= s_tdata[31:16];
			px_q     <= s_tdata[47:32];
			py_q     <= s_tdata[63:48];
			target_q <= s_tdata[74:64];
			bx_q     <= s_tdata[106:75];
			by_q     <= s_tdata[138:107];
		end
		if (state_q == ST_DECODE)
			new_size_q <= zoom_cand;
		if (state_q == ST_MUL)
			mul_q[step_q[0]] <= mul_prod;
		if (state_q == ST_LOAD) begin
			dneg_q <= dividend[DW-1];
			dmag_q <= dividend[DW-1] ? DW'(-dividend) : DW'(dividend);
			drem_q <= '0;
			dvsr_q <= divisor_sel;
		end
		if (state_q == ST_ITER) begin
			// one restoring step: shift in the next dividend bit, subtract if it fits
			drem_q <= trial_ge ? (trial - dvsr_q) : trial;
			dmag_q <= {dmag_q[DW-2:0], trial_ge};
		end
		if (state_q == ST_STORE) begin
			quo_q[step_q] <= q_signed;
			if (!step_q[1])
				rem_q[step_q[0]] <= r_signed;
		end
		if (state_q == ST_FINISH && out_free) begin
			out_data_q <= {4'b0, ncell, noy, nox, nmsy, nmsx, nmby, nmbx, ndone};
		end
	end

endmodule
